// ===== design/n2a_pkg.sv =====
package n2a_pkg;

   typedef logic [1:0] action_type;

   localparam action_type FMT_HEX16 = 2'd0;
   localparam action_type FMT_HEX32 = 2'd1;
   localparam action_type FMT_DEC16 = 2'd2;
   localparam action_type FMT_NONE  = 2'd3;

   localparam logic [7:0] CH_SPACE         = 8'h20;
   localparam logic [7:0] CH_ZERO          = 8'h30;
   localparam logic [7:0] CH_X             = 8'h78;
   localparam logic [7:0] HEX_ALPHA_OFFSET = 8'h37;
   localparam logic [3:0] HEX_DIGIT_LIMIT  = 4'hA;

   localparam int unsigned DEC_DIGITS = 5;
   localparam int unsigned MAX_CHARS  = 12;
   localparam int unsigned NUM_STG    = 5;

   localparam logic [3:0] LAST_HEX16 = 4'd7;
   localparam logic [3:0] LAST_HEX32 = 4'd11;
   localparam logic [3:0] LAST_DEC16 = 4'd6;

   localparam logic [13:0] W_10000 = 14'd10000;
   localparam logic [13:0] W_1000  = 14'd1000;
   localparam logic [13:0] W_100   = 14'd100;
   localparam logic [13:0] W_10    = 14'd10;

   typedef struct packed {
      action_type  action;
      logic [31:0] number;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   typedef struct packed {
      action_type                       action;
      logic [31:0]                      number;
      logic [13:0]                      rem;
      logic [0:DEC_DIGITS-1][3:0]       dig;
   } stage_type;

endpackage

// ===== design/number_to_ascii_formatter.sv =====
// Formats a 32-bit number as ASCII text, one character per rsp transaction, with
// rsp_payload.last set on the final character. action 0 gives " 0xHHHH " (8 chars),
// action 1 gives " 0xHHHHHHHH " (12 chars), action 2 gives " DDDDD " (7 chars, the low
// 16 bits zero-padded in decimal); action 3 is accepted and produces nothing. Decimal
// digits are peeled off over a five-stage pipeline (input register, then four stages of
// one decimal digit each, the last one also keeping the units digit), followed by a
// character serializer and an output register. The serializer sends one character per
// cycle while rsp_ready does not stall the output; transactions keep entering the
// pipeline while the previous one is still being sent.
module number_to_ascii_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  n2a_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output n2a_pkg::rsp_type  rsp_payload
);
   import n2a_pkg::*;

   function automatic logic [3:0] dec_quot(input logic [15:0] value,
                                           input logic [13:0] weight);
      logic [3:0] q;
      q = '0;
      for (int k = 1; k <= 9; k++) begin
         if (18'(value) >= 18'(k) * 18'(weight)) q = 4'(k);
      end
      return q;
   endfunction

   function automatic logic [13:0] dec_rem(input logic [15:0] value,
                                           input logic [3:0]  q,
                                           input logic [13:0] weight);
      logic [17:0] prod;
      prod = 18'(q) * 18'(weight);
      return 14'(18'(value) - prod);
   endfunction

   function automatic logic [3:0] last_idx(input action_type action);
      logic [3:0] r;
      unique case (action)
         FMT_HEX16: r = LAST_HEX16;
         FMT_HEX32: r = LAST_HEX32;
         default:   r = LAST_DEC16;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib >= HEX_DIGIT_LIMIT) r = {4'b0, nib} + HEX_ALPHA_OFFSET;
      else r = {4'b0, nib} + CH_ZERO;
      return r;
   endfunction

   function automatic logic [7:0] char_at(input stage_type s, input logic [3:0] idx);
      logic [7:0] r;
      logic [3:0] lst;
      logic [3:0] ni;
      lst = last_idx(s.action);
      ni  = lst - idx - 4'd1;
      if (idx == 4'd0 || idx == lst) begin
         r = CH_SPACE;
      end else if (s.action == FMT_DEC16) begin
         r = {4'b0, s.dig[3'(idx - 4'd1)]} + CH_ZERO;
      end else if (idx == 4'd1) begin
         r = CH_ZERO;
      end else if (idx == 4'd2) begin
         r = CH_X;
      end else begin
         r = hex_char(4'(s.number >> {ni[2:0], 2'b00}));
      end
      return r;
   endfunction

   // digit pipeline
   stage_type            stg_ff [NUM_STG];
   stage_type            stg_in [NUM_STG];
   logic [NUM_STG-1:0]   vld_ff;
   logic [NUM_STG-1:0]   vld_in;
   logic [NUM_STG-1:0]   stg_rdy;

   // serializer
   stage_type            ser_ff;
   logic                 ser_vld_ff;
   logic [3:0]           idx_ff;
   logic                 ser_rdy;
   logic                 emit;
   logic                 cur_last;
   logic [7:0]           cur_char;

   // output register
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   logic                 out_rdy;

   always_comb begin
      stg_in[0]        = '0;
      stg_in[0].action = req_payload.action;
      stg_in[0].number = req_payload.number;

      stg_in[1]        = stg_ff[0];
      stg_in[1].dig[0] = dec_quot(stg_ff[0].number[15:0], W_10000);
      stg_in[1].rem    = dec_rem(stg_ff[0].number[15:0], stg_in[1].dig[0], W_10000);

      stg_in[2]        = stg_ff[1];
      stg_in[2].dig[1] = dec_quot(16'(stg_ff[1].rem), W_1000);
      stg_in[2].rem    = dec_rem(16'(stg_ff[1].rem), stg_in[2].dig[1], W_1000);

      stg_in[3]        = stg_ff[2];
      stg_in[3].dig[2] = dec_quot(16'(stg_ff[2].rem), W_100);
      stg_in[3].rem    = dec_rem(16'(stg_ff[2].rem), stg_in[3].dig[2], W_100);

      stg_in[4]        = stg_ff[3];
      stg_in[4].dig[3] = dec_quot(16'(stg_ff[3].rem), W_10);
      stg_in[4].rem    = dec_rem(16'(stg_ff[3].rem), stg_in[4].dig[3], W_10);
      stg_in[4].dig[4] = stg_in[4].rem[3:0];
   end

   // unused format code is taken and dropped at the door
   always_comb begin
      vld_in[0] = req_valid && (req_payload.action != FMT_NONE);
      for (int k = 1; k < NUM_STG; k++) vld_in[k] = vld_ff[k-1];
   end

   always_comb begin
      stg_rdy[NUM_STG-1] = !vld_ff[NUM_STG-1] || ser_rdy;
      for (int k = NUM_STG - 2; k >= 0; k--) stg_rdy[k] = !vld_ff[k] || stg_rdy[k+1];
   end

   assign req_ready = stg_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STG; k++) begin
            if (stg_rdy[k]) vld_ff[k] <= vld_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STG; k++) begin
         if (stg_rdy[k]) stg_ff[k] <= stg_in[k];
      end
   end

   assign out_rdy  = !rsp_valid_ff || rsp_ready;
   assign cur_char = char_at(ser_ff, idx_ff);
   assign cur_last = (idx_ff == last_idx(ser_ff.action));
   assign emit     = ser_vld_ff && out_rdy;
   // next transaction loads as the last character leaves
   assign ser_rdy  = !ser_vld_ff || (emit && cur_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         idx_ff     <= '0;
      end else if (ser_rdy) begin
         ser_vld_ff <= vld_ff[NUM_STG-1];
         idx_ff     <= '0;
      end else if (emit) begin
         idx_ff <= idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_rdy) ser_ff <= stg_ff[NUM_STG-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy) begin
         rsp_ff.character <= cur_char;
         rsp_ff.last      <= cur_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/n2a_checker.sv =====
module n2a_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input n2a_pkg::req_type  req_payload,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input n2a_pkg::rsp_type  rsp_payload
);
   import n2a_pkg::*;

   logic       rsp_acc;
   logic       start_ff;
   logic       start_in;
   logic [3:0] cnt_ff;
   logic [3:0] cnt_in;

   assign rsp_acc = rsp_valid && rsp_ready;

   // position of the next character within its display
   always_comb begin
      start_in = start_ff;
      cnt_in   = cnt_ff;
      if (rsp_acc) begin
         start_in = rsp_payload.last;
         cnt_in   = rsp_payload.last ? 4'd0 : cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         start_ff <= start_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transaction completed");

   a_first_space: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && start_ff |-> rsp_payload.character == CH_SPACE)
      else $error("display does not open with a space");

   a_last_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_payload.last |->
         rsp_payload.character == CH_SPACE && cnt_ff >= LAST_DEC16)
      else $error("display closed early or without a trailing space");

   a_max_len: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && cnt_ff == 4'(MAX_CHARS - 1) |-> rsp_payload.last)
      else $error("display longer than the longest format");

endmodule

bind number_to_ascii_formatter n2a_checker u_n2a_checker (.*);
